>>> rtl/obis_pkg.sv
// shared types and constants for the obis identifier text parser
package obis_pkg;

	localparam int unsigned NumGroups = 6;
	localparam int unsigned GrpW = 8;

	typedef logic [2:0] grp_idx_t;
	typedef logic [NumGroups-1:0][GrpW-1:0] grp_vec_t;

	// group indexes, also the closed count after that group is closed minus one
	localparam grp_idx_t GRP_A = 3'd0;
	localparam grp_idx_t GRP_B = 3'd1;
	localparam grp_idx_t GRP_C = 3'd2;
	localparam grp_idx_t GRP_D = 3'd3;
	localparam grp_idx_t GRP_E = 3'd4;
	localparam grp_idx_t GRP_F = 3'd5;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_AMP = 8'h26;

	// n counts closed groups: 0 = none closed yet, 5 = a..e closed
	typedef struct packed {
		logic [GrpW-1:0] acc;
		grp_idx_t        n;
		logic            err;
		grp_vec_t        grp;
	} obis_state_t;

	typedef struct packed {
		grp_vec_t grp;
		logic     err;
	} obis_result_t;

	localparam obis_state_t OBIS_START = '{acc: '0, n: '0, err: 1'b0, grp: '1};

endpackage

>>> rtl/obis_step.sv
// next-state and result logic for one character of the identifier text
module obis_step (
	input  obis_pkg::obis_state_t  cur,
	input  logic [7:0]             ch,
	input  logic                   last,
	output obis_pkg::obis_state_t  nxt,
	output obis_pkg::obis_result_t res
);
	import obis_pkg::*;

	logic     sep_ok;
	grp_idx_t tgt;
	grp_idx_t fill_idx;
	logic [GrpW-1:0] acc_x10;

	// acc * 10 mod 256 as two shifts
	assign acc_x10 = {cur.acc[4:0], 3'b000} + {cur.acc[6:0], 1'b0};

	always_comb begin
		sep_ok = 1'b0;
		tgt = GRP_A;
		unique case (ch) inside
			CH_DASH: begin
				sep_ok = (cur.n < 3'd1);
				tgt = GRP_A;
			end
			CH_COLON: begin
				sep_ok = (cur.n < 3'd2);
				tgt = GRP_B;
			end
			CH_DOT: begin
				sep_ok = (cur.n < 3'd4);
				tgt = (cur.n < 3'd3) ? GRP_C : GRP_D;
			end
			CH_STAR, CH_AMP: begin
				sep_ok = (cur.n == 3'd4);
				tgt = GRP_E;
			end
			default: begin
				sep_ok = 1'b0;
				tgt = GRP_A;
			end
		endcase
	end

	always_comb begin
		nxt = cur;
		if (!cur.err) begin
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				nxt.acc = acc_x10 + {4'h0, ch[3:0]};
			end else if (sep_ok) begin
				nxt.grp[tgt] = cur.acc;
				nxt.acc = '0;
				nxt.n = tgt + 3'd1;
			end else begin
				nxt.err = 1'b1;
			end
		end

		// pending value lands in the group after the last closed one
		fill_idx = (nxt.n > GRP_F) ? GRP_F : nxt.n;
		res.grp = nxt.grp;
		res.err = nxt.err;
		if (!nxt.err) begin
			res.grp[fill_idx] = nxt.acc;
			res.err = (nxt.n < GRP_D);
		end

		if (last) begin
			nxt = OBIS_START;
		end
	end

endmodule

>>> rtl/obis_id_text_parser.sv
// top level of the obis identifier text parser
//
// channel  dir  fields (lsb first)               handshake
// s_axis   in   tdata: ch[7:0]; tlast: last      tvalid/tready
// m_axis   out  tdata: group_a..group_f, 8 each  tvalid/tready
//               tuser: parse_error
//
// one character per cycle while s_axis_tready is high; the result of the flagged last
// character shows on m_axis the cycle after it is taken, from a single output register.
// s_axis_tready drops only while that register holds a result not yet taken.
// arst_n puts the parser in its start state with all groups at 0xff.
module obis_id_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // ch[7:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // group_a, group_b, group_c, group_d, group_e, group_f
	output logic        m_axis_tuser   // parse_error
);
	import obis_pkg::*;

	obis_state_t  state_q;
	obis_state_t  state_nxt;
	obis_result_t res;
	obis_result_t out_q;
	logic         out_valid_q;
	logic         s_accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	obis_step u_step (
		.cur  (state_q),
		.ch   (s_axis_tdata),
		.last (s_axis_tlast),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OBIS_START;
		end else if (s_accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && s_axis_tlast) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q.grp;
	assign m_axis_tuser = out_q.err;

	// a frame end always returns the parser to its start state
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_axis_tlast |=> state_q == OBIS_START)
		else $error("parser not back at start after last character");

	// closed group count never goes past group e
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.n <= GRP_F)
		else $error("closed group count out of range");

	// a new result is loaded only by a last character
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s_accept && s_axis_tlast))
		else $error("result appeared without a last character");

	// an error latched mid-frame holds until the frame ends
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.err && s_accept && !s_axis_tlast |=> state_q.err)
		else $error("error flag lost inside a frame");

endmodule
